@@ rtl/size_to_suffixed_text_defines.svh @@
// Assertion macros shared by the size_to_suffixed_text RTL.
// Expects clk and arst_n in the scope of every use.
`ifndef SIZE_TO_SUFFIXED_TEXT_DEFINES_SVH
`define SIZE_TO_SUFFIXED_TEXT_DEFINES_SVH

`ifndef ASSERT_OFF
`define STT_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);
`define STT_ASSERT_IMPL(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);
`else
`define STT_ASSERT(lbl, prop, msg)
`define STT_ASSERT_IMPL(lbl, ante, cons, msg)
`endif

`endif

@@ rtl/stt_pkg.sv @@
// Types, constants and helper functions for size_to_suffixed_text.
// Used by stt_bcd and size_to_suffixed_text; depends on nothing.
package stt_pkg;

	localparam int AMOUNT_W  = 64;
	localparam int CHAR_W    = 7;
	localparam int BASE_W    = 11;
	localparam int LIMIT_W   = 14;
	localparam int CFG_IDX_W = 2;
	localparam int WORD_W    = 32;
	localparam int BASE10_W  = 15;
	localparam int MUL10_W   = 18;
	localparam int CONV_W    = 14;
	localparam int DIGITS    = 4;
	localparam int BCD_W     = 4 * DIGITS;
	localparam int STEPS_W   = 4;
	localparam int OUT_W     = 32;

	localparam logic [BASE_W-1:0]  BASE_MIN    = 11'd2;
	localparam logic [BASE_W-1:0]  BASE_RESET  = 11'd1024;
	localparam logic [LIMIT_W-1:0] LIMIT_RESET = 14'd1000;
	localparam logic [CHAR_W-1:0]  POINT_RESET = 7'd46;
	localparam logic [CONV_W-1:0]  PLAIN_MAX   = 14'd9999;
	localparam logic [CONV_W-1:0]  POINT_MAX   = 14'd99;
	localparam logic [CONV_W-1:0]  SMALL_LIMIT = 14'd1000;
	localparam logic [CHAR_W-1:0]  ASCII_SPACE = 7'h20;
	localparam logic [CHAR_W-1:0]  ASCII_ZERO  = 7'h30;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_SCALE_BASE  = 2'd0,
		CFG_PLAIN_LIMIT = 2'd1,
		CFG_POINT_CHAR  = 2'd2
	} cfg_idx_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_WIDE,
		S_NARROW,
		S_DIV,
		S_FRAC,
		S_CONV,
		S_EMIT
	} state_t;

	typedef enum logic [1:0] {
		M_PLAIN,
		M_SUFFIX,
		M_POINT
	} mode_t;

	function automatic logic [CHAR_W-1:0] digit_char(input logic [3:0] d);
		return ASCII_ZERO + CHAR_W'(d);
	endfunction

	function automatic logic [CHAR_W-1:0] suffix_char(input logic [STEPS_W:0] idx);
		logic [CHAR_W-1:0] c;
		case (idx)
			5'd0:    c = 7'h62; // b
			5'd1:    c = 7'h6B; // k
			5'd2:    c = 7'h4D; // M
			5'd3:    c = 7'h47; // G
			5'd4:    c = 7'h54; // T
			5'd5:    c = 7'h50; // P
			5'd6:    c = 7'h45; // E
			5'd7:    c = 7'h5A; // Z
			default: c = 7'h59; // Y, saturated
		endcase
		return c;
	endfunction

endpackage

@@ rtl/size_to_suffixed_text.sv @@
// size_to_suffixed_text: renders an unsigned amount as four ASCII characters,
// either a plain right-aligned number or a scaled value with a suffix letter.
// Input: s_tvalid/s_tready/s_tdata carry one amount per transaction.
// Output: m_tvalid/m_tready/m_tdata carry the four characters of the text.
// Config: cfg_valid/cfg_ready/cfg_index/cfg_data write scale_base (0),
// plain_limit (1) and point_char (2); cfg_ready is always high and writes
// to index 3 are dropped. Write configuration only while the block is idle.
// One amount is in flight at a time. A shared restoring divider produces
// one quotient bit per cycle; the decimal digits come from a bit-serial BCD
// converter. Zero and plain numbers need no division, a point digit needs
// one of its own, and the largest 64-bit amount at base 1024 takes six.
// The next amount can be taken in the cycle after the result enters the
// output register, even while that result still waits.
// If the receiver stalls, the finished result holds in the output
// register and the next one holds in the sequencer until the slot frees.
// Reset clears the sequencer and output valid and loads the register
// defaults 1024, 1000 and '.'.
// Depends on stt_pkg, stt_bcd and size_to_suffixed_text_defines.svh.
`include "size_to_suffixed_text_defines.svh"

module size_to_suffixed_text
	import stt_pkg::*;
#(
	parameter int AMOUNT_BITS = 64
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 s_tvalid,
	output logic                 s_tready,
	input  logic [AMOUNT_W-1:0]  s_tdata,   // [63:0] amount
	output logic                 m_tvalid,
	input  logic                 m_tready,
	output logic [OUT_W-1:0]     m_tdata,   // [6:0] char_first, [13:7] char_second,
	                                        // [20:14] char_third, [27:21] char_fourth,
	                                        // [31:28] zero
	input  logic                 cfg_valid,
	output logic                 cfg_ready,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [LIMIT_W-1:0]   cfg_data
);

	localparam int AW    = AMOUNT_BITS;
	localparam int CNT_W = $clog2(AW);

	logic [BASE_W-1:0]  scale_base_q;
	logic [LIMIT_W-1:0] plain_limit_q;
	logic [CHAR_W-1:0]  point_char_q;

	state_t               state_q, state_d, ret_q, ret_d;
	mode_t                mode_q, mode_d;
	logic [AW-1:0]        val_q;
	logic [BASE_W-1:0]    rem_q;
	logic [BASE_W-1:0]    base_q;
	logic [CNT_W-1:0]     cnt_q;
	logic [STEPS_W-1:0]   steps_q;
	logic                 m_tvalid_q;
	logic [CHAR_W-1:0]    c0_q, c1_q, c2_q, c3_q;

	logic                 div_go, step_go, conv_go, mul10_go, emit_go;
	logic [CONV_W-1:0]    conv_val;
	logic [BCD_W-1:0]     bcd;
	logic                 conv_done;

	logic [WORD_W-1:0]    low32;
	logic                 val_zero, val_wide, val_plain, val_big, val_small;
	logic [BASE10_W-1:0]  base10;
	logic [MUL10_W-1:0]   times10;
	logic [BASE_W:0]      rem_next;
	logic                 rem_ge;
	logic [CONV_W-1:0]    plain_sat, frac_sat;
	logic [3:0]           d0, d1, d2, d3;
	logic [CHAR_W-1:0]    f0, f1, f2, f3;
	logic [STEPS_W:0]     steps_ext;

	// configuration registers
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			scale_base_q  <= BASE_RESET;
			plain_limit_q <= LIMIT_RESET;
			point_char_q  <= POINT_RESET;
		end else if (cfg_valid) begin
			case (cfg_index)
				CFG_SCALE_BASE:  scale_base_q  <= cfg_data[BASE_W-1:0];
				CFG_PLAIN_LIMIT: plain_limit_q <= cfg_data;
				CFG_POINT_CHAR:  point_char_q  <= cfg_data[CHAR_W-1:0];
				default: ;
			endcase
		end
	end

	// value tests
	assign low32     = val_q[WORD_W-1:0];
	assign val_zero  = (val_q == '0);
	assign val_wide  = (|val_q[AW-1:WORD_W]) || (&low32);
	assign val_plain = (steps_q == '0) && (low32 < WORD_W'(plain_limit_q));
	assign base10    = ({4'b0, base_q} << 3) + ({4'b0, base_q} << 1);
	assign val_big   = (low32 >= WORD_W'(base10));
	assign val_small = (low32 < WORD_W'(SMALL_LIMIT));
	assign times10   = ({3'b0, val_q[BASE10_W-1:0]} << 3)
	                 + ({3'b0, val_q[BASE10_W-1:0]} << 1);
	assign plain_sat = (low32 > WORD_W'(PLAIN_MAX)) ? PLAIN_MAX : low32[CONV_W-1:0];
	assign frac_sat  = (low32 > WORD_W'(POINT_MAX)) ? POINT_MAX : low32[CONV_W-1:0];

	// divider step
	assign rem_next = {rem_q, val_q[AW-1]};
	assign rem_ge   = (rem_next >= {1'b0, base_q});

	// sequencer
	always_comb begin
		state_d  = state_q;
		ret_d    = ret_q;
		mode_d   = mode_q;
		div_go   = 1'b0;
		step_go  = 1'b0;
		conv_go  = 1'b0;
		conv_val = '0;
		mul10_go = 1'b0;
		emit_go  = 1'b0;
		case (state_q)
			S_IDLE: begin
				if (s_tvalid) begin
					state_d = S_WIDE;
				end
			end
			S_WIDE: begin
				if (val_zero) begin
					conv_go = 1'b1;
					mode_d  = M_PLAIN;
					state_d = S_CONV;
				end else if (val_wide) begin
					div_go  = 1'b1;
					step_go = 1'b1;
					ret_d   = S_WIDE;
					state_d = S_DIV;
				end else if (val_plain) begin
					conv_go  = 1'b1;
					conv_val = plain_sat;
					mode_d   = M_PLAIN;
					state_d  = S_CONV;
				end else begin
					state_d = S_NARROW;
				end
			end
			S_NARROW: begin
				if (val_big) begin
					div_go  = 1'b1;
					step_go = 1'b1;
					ret_d   = S_NARROW;
					state_d = S_DIV;
				end else if (val_small) begin
					conv_go  = 1'b1;
					conv_val = low32[CONV_W-1:0];
					mode_d   = M_SUFFIX;
					state_d  = S_CONV;
				end else begin
					mul10_go = 1'b1;
					div_go   = 1'b1;
					ret_d    = S_FRAC;
					state_d  = S_DIV;
				end
			end
			S_DIV: begin
				if (cnt_q == '0) begin
					state_d = ret_q;
				end
			end
			S_FRAC: begin
				conv_go  = 1'b1;
				conv_val = frac_sat;
				mode_d   = M_POINT;
				state_d  = S_CONV;
			end
			S_CONV: begin
				if (conv_done) begin
					state_d = S_EMIT;
				end
			end
			S_EMIT: begin
				if (!m_tvalid_q || m_tready) begin
					emit_go = 1'b1;
					state_d = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			ret_q   <= S_IDLE;
			mode_q  <= M_PLAIN;
			cnt_q   <= '0;
			steps_q <= '0;
		end else begin
			state_q <= state_d;
			ret_q   <= ret_d;
			mode_q  <= mode_d;
			if (div_go) begin
				cnt_q <= CNT_W'(AW - 1);
			end else if (state_q == S_DIV) begin
				cnt_q <= cnt_q - 1'b1;
			end
			if (state_q == S_IDLE) begin
				steps_q <= '0;
			end else if (step_go && (steps_q != '1)) begin
				steps_q <= steps_q + 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == S_IDLE && s_tvalid) begin
			val_q  <= s_tdata[AW-1:0];
			base_q <= (scale_base_q < BASE_MIN) ? BASE_MIN : scale_base_q;
		end else if (mul10_go) begin
			val_q <= AW'(times10);
		end else if (state_q == S_DIV) begin
			val_q <= {val_q[AW-2:0], rem_ge};
		end
		if (div_go) begin
			rem_q <= '0;
		end else if (state_q == S_DIV) begin
			rem_q <= rem_ge ? BASE_W'(rem_next - {1'b0, base_q}) : rem_next[BASE_W-1:0];
		end
	end

	assign s_tready = (state_q == S_IDLE);

	stt_bcd u_bcd (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (conv_go),
		.value  (conv_val),
		.bcd    (bcd),
		.done   (conv_done)
	);

	// text formatting
	assign d0        = bcd[3:0];
	assign d1        = bcd[7:4];
	assign d2        = bcd[11:8];
	assign d3        = bcd[15:12];
	assign steps_ext = {1'b0, steps_q};

	always_comb begin
		case (mode_q)
			M_PLAIN: begin
				f0 = (d3 == 4'd0) ? ASCII_SPACE : digit_char(d3);
				f1 = (d3 == 4'd0 && d2 == 4'd0) ? ASCII_SPACE : digit_char(d2);
				f2 = (d3 == 4'd0 && d2 == 4'd0 && d1 == 4'd0) ? ASCII_SPACE : digit_char(d1);
				f3 = digit_char(d0);
			end
			M_SUFFIX: begin
				f0 = (d2 == 4'd0) ? ASCII_SPACE : digit_char(d2);
				f1 = (d2 == 4'd0 && d1 == 4'd0) ? ASCII_SPACE : digit_char(d1);
				f2 = digit_char(d0);
				f3 = suffix_char(steps_ext);
			end
			M_POINT: begin
				f0 = digit_char(d1);
				f1 = point_char_q;
				f2 = digit_char(d0);
				f3 = suffix_char(steps_ext + 1'b1);
			end
			default: begin
				f0 = ASCII_SPACE;
				f1 = ASCII_SPACE;
				f2 = ASCII_SPACE;
				f3 = ASCII_ZERO;
			end
		endcase
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if (emit_go) begin
			m_tvalid_q <= 1'b1;
		end else if (m_tready) begin
			m_tvalid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (emit_go) begin
			c0_q <= f0;
			c1_q <= f1;
			c2_q <= f2;
			c3_q <= f3;
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = {4'b0, c3_q, c2_q, c1_q, c0_q};

	`STT_ASSERT(a_rem_below_base, (state_q != S_DIV) || (rem_q < base_q), "divider remainder not below base")
	`STT_ASSERT_IMPL(a_base_floor, state_q != S_IDLE, base_q >= BASE_MIN, "working base below two")
	`STT_ASSERT_IMPL(a_narrow_fits, state_q == S_NARROW, val_q[AW-1:WORD_W] == '0, "narrow phase value wider than a word")
	`STT_ASSERT_IMPL(a_steps_grow, (state_q != S_IDLE) && ($past(state_q) != S_IDLE), steps_q >= $past(steps_q), "suffix step count went down")

endmodule

@@ rtl/stt_bcd.sv @@
// Bit-serial binary to BCD converter (shift and add three), one bit per cycle.
// Depends on stt_pkg and size_to_suffixed_text_defines.svh.
`include "size_to_suffixed_text_defines.svh"

module stt_bcd
	import stt_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	input  logic [CONV_W-1:0] value,
	output logic [BCD_W-1:0]  bcd,
	output logic              done
);

	localparam int CNT_W = $clog2(CONV_W);

	logic [CONV_W-1:0] bin_q;
	logic [BCD_W-1:0]  bcd_q;
	logic [BCD_W-1:0]  adj;
	logic [CNT_W-1:0]  cnt_q;
	logic              busy_q;

	always_comb begin
		for (int i = 0; i < DIGITS; i++) begin
			adj[i*4 +: 4] = (bcd_q[i*4 +: 4] >= 4'd5) ? bcd_q[i*4 +: 4] + 4'd3
			                                          : bcd_q[i*4 +: 4];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			cnt_q  <= CNT_W'(CONV_W - 1);
		end else if (busy_q) begin
			cnt_q <= cnt_q - 1'b1;
			if (cnt_q == '0) begin
				busy_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			bin_q <= value;
			bcd_q <= '0;
		end else if (busy_q) begin
			bin_q <= {bin_q[CONV_W-2:0], 1'b0};
			bcd_q <= {adj[BCD_W-2:0], bin_q[CONV_W-1]};
		end
	end

	assign bcd  = bcd_q;
	assign done = busy_q && (cnt_q == '0);

	`STT_ASSERT(a_bcd_digits_valid, !busy_q || ((bcd_q[3:0] <= 4'd9) && (bcd_q[7:4] <= 4'd9) && (bcd_q[11:8] <= 4'd9) && (bcd_q[15:12] <= 4'd9)), "BCD digit above nine during conversion")

endmodule

@@ verif/tb_size_to_suffixed_text.sv @@
// Self-checking testbench for size_to_suffixed_text: directed table, then random phases.
// Predicts (or pins) each four-char text in SystemVerilog, compares it per character.
// Depends on stt_pkg and the size_to_suffixed_text RTL.
module tb_size_to_suffixed_text;
	import stt_pkg::*;

	localparam int AMOUNT_BITS = 64;
	localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 2'd3;
	localparam logic [71:0] SUFFIX_LETTERS = "bkMGTPEZY";
	localparam logic [63:0] WORD_LIMIT = 64'hFFFF_FFFF;

	typedef struct packed {
		logic [CHAR_W-1:0] ch_fourth;
		logic [CHAR_W-1:0] ch_third;
		logic [CHAR_W-1:0] ch_second;
		logic [CHAR_W-1:0] ch_first;
	} text_t;

	typedef struct packed {
		logic        fixed;
		text_t       txt;
	} pinned_t;

	typedef struct packed {
		logic [63:0] amount;
		logic        fixed;
		logic [31:0] ascii;
	} directed_row_t;

	typedef struct packed {
		logic [LIMIT_W-1:0] base_word;
		logic [LIMIT_W-1:0] limit_word;
		logic [LIMIT_W-1:0] point_word;
		logic [7:0]         idle_pct;
		logic [7:0]         stall_pct;
		logic [15:0]        count;
		logic [7:0]         max_bits;
	} phase_t;

	localparam directed_row_t DIRECTED [22] = '{
		'{64'd0, 1'b1, "   0"},
		'{64'd1, 1'b1, "   1"},
		'{64'd9, 1'b0, 32'd0},
		'{64'd10, 1'b0, 32'd0},
		'{64'd99, 1'b0, 32'd0},
		'{64'd100, 1'b0, 32'd0},
		'{64'd999, 1'b1, " 999"},
		'{64'd1000, 1'b1, "0.9k"},
		'{64'd1023, 1'b0, 32'd0},
		'{64'd1024, 1'b0, 32'd0},
		'{64'd10239, 1'b0, 32'd0},
		'{64'd10240, 1'b0, 32'd0},
		'{64'd1048575, 1'b0, 32'd0},
		'{64'd1048576, 1'b0, 32'd0},
		'{64'hFFFF_FFFE, 1'b0, 32'd0},
		'{64'hFFFF_FFFF, 1'b0, 32'd0},
		'{64'h1_0000_0000, 1'b0, 32'd0},
		'{64'h8000_0000_0000_0000, 1'b0, 32'd0},
		'{64'hFFFF_FFFF_FFFF_FFFF, 1'b1, " 15E"},
		'{64'h5555_5555_5555_5555, 1'b0, 32'd0},
		'{64'hAAAA_AAAA_AAAA_AAAA, 1'b0, 32'd0},
		'{64'h0123_4567_89AB_CDEF, 1'b0, 32'd0}
	};

	localparam phase_t FIXED_PHASES [7] = '{
		'{14'd1024, 14'd1000, 14'd46, 8'd0, 8'd0, 16'd220, 8'd64},
		'{14'd1000, 14'd10000, 14'd44, 8'd58, 8'd0, 16'd220, 8'd64},
		'{14'd256, 14'd0, 14'd32, 8'd0, 8'd58, 16'd220, 8'd64},
		'{14'h3FFF, 14'h3FFF, 14'h3FFF, 8'd23, 8'd23, 16'd220, 8'd64},
		'{14'd0, 14'd16383, 14'd0, 8'd0, 8'd0, 16'd30, 8'd40},
		'{14'd1, 14'd5000, 14'd127, 8'd23, 8'd23, 16'd20, 8'd64},
		'{14'd101, 14'd1, 14'd31, 8'd58, 8'd0, 16'd150, 8'd64}
	};

	localparam int RANDOM_PHASES = 4;
	localparam int RANDOM_COUNT = 100;

	logic                 clk;
	logic                 arst_n = 1'b0;
	logic                 s_tvalid = 1'b0;
	logic                 s_tready;
	logic [AMOUNT_W-1:0]  s_tdata = '0;
	logic                 m_tvalid;
	logic                 m_tready = 1'b0;
	logic [OUT_W-1:0]     m_tdata;
	logic                 cfg_valid = 1'b0;
	logic                 cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [LIMIT_W-1:0]   cfg_data = '0;

	logic [BASE_W-1:0]  cur_base = BASE_RESET;
	logic [LIMIT_W-1:0] cur_limit = LIMIT_RESET;
	logic [CHAR_W-1:0]  cur_point = POINT_RESET;

	text_t   pending_texts [$];
	pinned_t pinned_texts [$];
	int      mismatch_count = 0;
	int      send_idle_pct = 0;
	int      recv_stall_pct = 0;

	size_to_suffixed_text #(
		.AMOUNT_BITS(AMOUNT_BITS)
	) DUT (
		.clk(clk),
		.arst_n(arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		#50_000_000;
		$display("*** FAILED ***");
		$finish;
	end

	function automatic logic [CHAR_W-1:0] pad_digit(input logic [31:0] v, input logic [31:0] div);
		if (v < div) begin
			return ASCII_SPACE;
		end
		return ASCII_ZERO + CHAR_W'((v / div) % 10);
	endfunction

	function automatic logic [CHAR_W-1:0] suffix_letter(input int idx);
		int k;
		k = (idx > 8) ? 8 : idx;
		return SUFFIX_LETTERS[8 * (8 - k) +: CHAR_W];
	endfunction

	function automatic logic [31:0] effective_base();
		return (cur_base < 2) ? 32'd2 : 32'(cur_base);
	endfunction

	function automatic text_t render_amount(input logic [AMOUNT_W-1:0] amount);
		logic [AMOUNT_W-1:0] big;
		logic [31:0]         base;
		logic [31:0]         q;
		logic [31:0]         t;
		int                  steps;
		text_t               txt;
		big = amount & ({AMOUNT_W{1'b1}} >> (AMOUNT_W - AMOUNT_BITS));
		base = effective_base();
		steps = 0;
		if (big == 0) begin
			txt.ch_first = ASCII_SPACE;
			txt.ch_second = ASCII_SPACE;
			txt.ch_third = ASCII_SPACE;
			txt.ch_fourth = ASCII_ZERO;
			return txt;
		end
		while (big >= WORD_LIMIT) begin
			steps++;
			big = big / AMOUNT_W'(base);
		end
		q = big[31:0];
		if (steps == 0 && q < 32'(cur_limit)) begin
			if (q > 9999) begin
				q = 9999;
			end
			txt.ch_first = pad_digit(q, 1000);
			txt.ch_second = pad_digit(q, 100);
			txt.ch_third = pad_digit(q, 10);
			txt.ch_fourth = ASCII_ZERO + CHAR_W'(q % 10);
			return txt;
		end
		while (q >= base * 10) begin
			steps++;
			q = q / base;
		end
		if (q < 1000) begin
			txt.ch_first = pad_digit(q, 100);
			txt.ch_second = pad_digit(q, 10);
			txt.ch_third = ASCII_ZERO + CHAR_W'(q % 10);
			txt.ch_fourth = suffix_letter(steps);
		end else begin
			t = (q * 10) / base;
			if (t > 99) begin
				t = 99;
			end
			txt.ch_first = ASCII_ZERO + CHAR_W'(t / 10);
			txt.ch_second = cur_point;
			txt.ch_third = ASCII_ZERO + CHAR_W'(t % 10);
			txt.ch_fourth = suffix_letter(steps + 1);
		end
		return txt;
	endfunction

	function automatic logic [63:0] pick_amount(input int max_bits);
		logic [63:0] raw;
		logic [63:0] p;
		int          w;
		raw = {$urandom(), $urandom()};
		case ($urandom_range(0, 11))
			0, 1: return 64'($urandom_range(0, 20000));
			2: return 64'(cur_limit) + 64'($urandom_range(0, 4)) - 64'd2;
			3: return WORD_LIMIT + 64'($urandom_range(0, 4)) - 64'd2;
			4: return ({64{1'b1}} >> (64 - max_bits)) - 64'($urandom_range(0, 3));
			5: begin
				p = 64'(effective_base()) * 10;
				repeat ($urandom_range(0, 3)) p = p * 64'(effective_base());
				return p + 64'($urandom_range(0, 2)) - 64'd1;
			end
			default: begin
				w = $urandom_range(1, max_bits);
				return raw >> (64 - w);
			end
		endcase
	endfunction

	task automatic compare_char(input string field_name, input logic [CHAR_W-1:0] want,
			input logic [CHAR_W-1:0] got);
		if (got !== want) begin
			mismatch_count++;
			$display("%0t: %s expected 0x%h, got 0x%h", $time, field_name, want, got);
		end
	endtask

	always @(posedge clk) begin
		text_t want;
		text_t got;
		pinned_t pin;
		m_tready <= ($urandom_range(0, 99) >= recv_stall_pct);
		if (arst_n) begin
			if (m_tvalid && m_tready) begin
				got = text_t'(m_tdata[4*CHAR_W-1:0]);
				if (pending_texts.size() == 0) begin
					mismatch_count++;
					$display("%0t: result 0x%h arrived with no amount outstanding",
						$time, m_tdata);
				end else begin
					want = pending_texts.pop_front();
					compare_char("char_first", want.ch_first, got.ch_first);
					compare_char("char_second", want.ch_second, got.ch_second);
					compare_char("char_third", want.ch_third, got.ch_third);
					compare_char("char_fourth", want.ch_fourth, got.ch_fourth);
				end
			end
			if (s_tvalid && s_tready) begin
				if (pinned_texts.size() != 0) begin
					pin = pinned_texts.pop_front();
					pending_texts.push_back(pin.fixed ? pin.txt : render_amount(s_tdata));
				end else begin
					pending_texts.push_back(render_amount(s_tdata));
				end
			end
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					CFG_SCALE_BASE:  cur_base = cfg_data[BASE_W-1:0];
					CFG_PLAIN_LIMIT: cur_limit = cfg_data;
					CFG_POINT_CHAR:  cur_point = cfg_data[CHAR_W-1:0];
					default: ;
				endcase
			end
		end
	end

	task automatic send_amount(input logic [63:0] amount);
		int gap;
		gap = 0;
		while ($urandom_range(0, 99) < send_idle_pct) gap++;
		if (send_idle_pct != 0 && $urandom_range(0, 15) == 0) begin
			gap += $urandom_range(1, 300);
		end
		if (gap != 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= amount;
		do @(posedge clk); while (!s_tready);
	endtask

	task automatic settle();
		s_tvalid <= 1'b0;
		@(posedge clk);
		while (pending_texts.size() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic apply_settings(input logic [LIMIT_W-1:0] base_word,
			input logic [LIMIT_W-1:0] limit_word, input logic [LIMIT_W-1:0] point_word);
		logic [CFG_IDX_W-1:0] order [4];
		logic [LIMIT_W-1:0]   words [4];
		order = '{CFG_SCALE_BASE, CFG_PLAIN_LIMIT, CFG_POINT_CHAR, CFG_UNUSED};
		words = '{base_word, limit_word, point_word, LIMIT_W'($urandom)};
		for (int i = 0; i < 4; i++) begin
			cfg_valid <= 1'b1;
			cfg_index <= order[i];
			cfg_data <= words[i];
			do @(posedge clk); while (!cfg_ready);
		end
		cfg_valid <= 1'b0;
	endtask

	task automatic run_phase(input phase_t ph);
		settle();
		apply_settings(ph.base_word, ph.limit_word, ph.point_word);
		send_idle_pct = ph.idle_pct;
		recv_stall_pct = ph.stall_pct;
		repeat (ph.count) send_amount(pick_amount(ph.max_bits));
	endtask

	initial begin
		pinned_t pin;
		phase_t  ph;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		foreach (DIRECTED[i]) begin
			pin.fixed = DIRECTED[i].fixed;
			pin.txt.ch_first = DIRECTED[i].ascii[30:24];
			pin.txt.ch_second = DIRECTED[i].ascii[22:16];
			pin.txt.ch_third = DIRECTED[i].ascii[14:8];
			pin.txt.ch_fourth = DIRECTED[i].ascii[6:0];
			pinned_texts.push_back(pin);
			send_amount(DIRECTED[i].amount);
		end
		foreach (FIXED_PHASES[i]) run_phase(FIXED_PHASES[i]);
		for (int i = 0; i < RANDOM_PHASES; i++) begin
			ph.base_word = {3'($urandom), 11'($urandom_range(256, 2047))};
			ph.limit_word = LIMIT_W'($urandom);
			ph.point_word = LIMIT_W'($urandom);
			ph.idle_pct = (i % 2 == 1) ? ((i == 3) ? 8'd23 : 8'd58) : 8'd0;
			ph.stall_pct = (i >= 2) ? ((i == 3) ? 8'd23 : 8'd58) : 8'd0;
			ph.count = RANDOM_COUNT;
			ph.max_bits = 64;
			run_phase(ph);
		end
		settle();
		repeat (200) @(posedge clk);
		if (mismatch_count == 0) begin
			$display("*** PASSED ***");
		end else begin
			$display("*** FAILED ***");
		end
		$finish;
	end

endmodule
